FILE: design/hft_pkg.sv
// ----------------------------------------------------------------------------
// hft_pkg: shared types and constants of the header field tokenizer
// Holds the event codes, the parser phase, the result record and the
// character constants that the tokenizer compares against.
// ----------------------------------------------------------------------------
`default_nettype none

package hft_pkg;

  // Reset value of the field limit register.
  localparam logic [15:0] MaxFieldsReset = 16'd5000;

  // Characters with a special meaning in a header.
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharNul   = 8'h00;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_NAME_BYTE    = 3'd0,
    EV_VALUE_BYTE   = 3'd1,
    EV_NAME_DONE    = 3'd2,
    EV_FIELD_DONE   = 3'd3,
    EV_HEADER_DONE  = 3'd4,
    EV_UNTERMINATED = 3'd5,
    EV_EMPTY_VALUE  = 3'd6,
    EV_TOO_MANY     = 3'd7
  } event_e;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_NAME  = 2'd0,
    PH_VALUE = 2'd1,
    PH_STOP  = 2'd2
  } phase_e;

  // One result item.
  typedef struct packed {
    logic [7:0]  out_byte;
    event_e      ev;
    logic [15:0] field_index;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

FILE: design/header_field_tokenizer.sv
// ----------------------------------------------------------------------------
// header_field_tokenizer: message header splitter with line unfolding
// Splits raw header bytes into compacted name and value bytes and field
// events, unfolds continuation lines and flags malformed headers.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   -------   ---------  ------------------------  --------------------------
//   input     in         in_valid_i / in_stall_o   first_i, in_byte_i
//   result    out        out_valid_o / out_stall_i out_byte_o, event_res_o,
//                                                  field_index_o, last_o
//   config    in         cfg_valid_i / cfg_ready_o cfg_data_i (max_fields)
//
// A byte is decoded in the cycle it is accepted; its results appear at the
// output in the next cycle. One byte per cycle is sustained while the output
// is not stalled and each byte gives at most one result; a byte that gives
// two results stalls the input while the second result waits in the second
// slot of the two-entry result buffer.
// Reset puts the parser in the name phase with the field count at zero and
// loads the field limit with 5000. A stall on the output holds the buffer
// and stalls the input once the buffer cannot take another byte's results.
// ----------------------------------------------------------------------------
`default_nettype none

module header_field_tokenizer (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input byte channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        first_i,
  input  wire logic [7:0]  in_byte_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic [2:0]       event_res_o,
  output logic [15:0]      field_index_o,
  output logic             last_o,
  // Configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [15:0] cfg_data_i
);

  import hft_pkg::*;

  // Configuration and parser state.
  logic [15:0] max_fields_q;
  phase_e      phase_q, phase_d;
  logic        raw_seen_q, raw_seen_d;
  logic        skip_q, skip_d;
  logic        space_q, space_d;
  logic        eol_q, eol_d;
  logic [15:0] count_q, count_d;

  // Result buffer: slot A drives the output, slot B holds a second result.
  result_t     a_q, b_q;
  logic        a_valid_q, b_valid_q;

  // Decode results of the current byte.
  result_t     res [2];
  logic [1:0]  res_n;

  logic        in_xfer;
  logic        out_xfer;

  // Byte classes.
  logic        is_eol, is_blank, is_space;

  assign is_eol   = (in_byte_i == CharLf) || (in_byte_i == CharCr);
  assign is_blank = (in_byte_i == CharSpace) || (in_byte_i == CharTab);
  assign is_space = (in_byte_i == CharSpace) || (in_byte_i inside {[8'd9:8'd13]});

  // Handshakes.
  assign out_xfer    = a_valid_q && !out_stall_i;
  assign in_stall_o  = a_valid_q && (out_stall_i || b_valid_q);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  // Decode one byte: next parser state and up to two results.
  always_comb begin
    logic   deferred;
    logic   body;
    event_e body_ev;
    logic [15:0] count_inc;

    phase_d    = phase_q;
    raw_seen_d = raw_seen_q;
    skip_d     = skip_q;
    space_d    = space_q;
    eol_d      = eol_q;
    count_d    = count_q;
    res[0]     = '0;
    res[1]     = '0;
    res_n      = 2'd0;
    deferred   = 1'b0;
    body       = 1'b0;
    count_inc  = '0;

    // A first byte restarts the parser.
    if (first_i) begin
      phase_d    = PH_NAME;
      count_d    = '0;
      raw_seen_d = 1'b0;
      skip_d     = 1'b1;
      space_d    = 1'b0;
      eol_d      = 1'b0;
    end

    // A held line end in a value: fold on blank, otherwise flag an empty value or close the field.
    if (phase_d == PH_VALUE && eol_d) begin
      eol_d = 1'b0;
      if (is_blank) begin
        raw_seen_d = 1'b1;
        if (!skip_d) begin
          skip_d  = 1'b1;
          space_d = 1'b1;
        end
        deferred = 1'b1;
      end else if (!raw_seen_d) begin
        res[res_n[0]] = '{out_byte: CharNul, ev: EV_EMPTY_VALUE,
                          field_index: count_d, last: 1'b0};
        res_n   = res_n + 2'd1;
        phase_d = PH_STOP;
      end else begin
        res[res_n[0]] = '{out_byte: CharNul, ev: EV_FIELD_DONE,
                          field_index: count_d, last: 1'b0};
        res_n     = res_n + 2'd1;
        count_inc = count_d + 16'd1;
        if (count_inc >= max_fields_q) begin
          res[res_n[0]] = '{out_byte: CharNul, ev: EV_TOO_MANY,
                            field_index: count_d, last: 1'b0};
          res_n   = res_n + 2'd1;
          phase_d = PH_STOP;
        end else begin
          phase_d    = PH_NAME;
          raw_seen_d = 1'b0;
          skip_d     = 1'b1;
          space_d    = 1'b0;
        end
        count_d = count_inc;
      end
    end

    // Name and value handling of the byte itself.
    if (!deferred) begin
      case (phase_d)
        PH_NAME: begin
          if (in_byte_i == CharColon || is_eol) begin
            if (!raw_seen_d) begin
              res[res_n[0]] = '{out_byte: CharNul, ev: EV_HEADER_DONE,
                                field_index: count_d, last: 1'b0};
              res_n   = res_n + 2'd1;
              phase_d = PH_STOP;
            end else begin
              res[res_n[0]] = '{out_byte: CharNul, ev: EV_NAME_DONE,
                                field_index: count_d, last: 1'b0};
              res_n      = res_n + 2'd1;
              phase_d    = PH_VALUE;
              raw_seen_d = 1'b0;
              skip_d     = 1'b1;
              space_d    = 1'b0;
              eol_d      = 1'b0;
            end
          end else if (in_byte_i == CharNul) begin
            res[res_n[0]] = '{out_byte: CharNul,
                              ev: raw_seen_d ? EV_UNTERMINATED : EV_HEADER_DONE,
                              field_index: count_d, last: 1'b0};
            res_n   = res_n + 2'd1;
            phase_d = PH_STOP;
          end else begin
            body = 1'b1;
          end
        end
        PH_VALUE: begin
          if (in_byte_i == CharNul) begin
            res[res_n[0]] = '{out_byte: CharNul, ev: EV_UNTERMINATED,
                              field_index: count_d, last: 1'b0};
            res_n   = res_n + 2'd1;
            phase_d = PH_STOP;
          end else if (is_eol) begin
            eol_d = 1'b1;
          end else begin
            body = 1'b1;
          end
        end
        default: begin
          // Stopped: the byte is ignored.
        end
      endcase
    end

    // Whitespace compaction of a name or value byte.
    body_ev = (phase_d == PH_NAME) ? EV_NAME_BYTE : EV_VALUE_BYTE;
    if (body) begin
      raw_seen_d = 1'b1;
      if (is_space) begin
        if (!skip_d) begin
          skip_d  = 1'b1;
          space_d = 1'b1;
        end
      end else begin
        if (space_d) begin
          res[res_n[0]] = '{out_byte: CharSpace, ev: body_ev,
                            field_index: count_d, last: 1'b0};
          res_n = res_n + 2'd1;
        end
        res[res_n[0]] = '{out_byte: in_byte_i, ev: body_ev,
                          field_index: count_d, last: 1'b0};
        res_n   = res_n + 2'd1;
        space_d = 1'b0;
        skip_d  = 1'b0;
      end
    end

    // Mark the final result of this byte.
    if (res_n == 2'd2) begin
      res[1].last = 1'b1;
    end else begin
      res[0].last = 1'b1;
    end
  end

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fields_q <= MaxFieldsReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_fields_q <= cfg_data_i;
    end
  end

  // Parser state, updated on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_NAME;
      raw_seen_q <= 1'b0;
      skip_q     <= 1'b1;
      space_q    <= 1'b0;
      eol_q      <= 1'b0;
      count_q    <= '0;
    end else if (in_xfer) begin
      phase_q    <= phase_d;
      raw_seen_q <= raw_seen_d;
      skip_q     <= skip_d;
      space_q    <= space_d;
      eol_q      <= eol_d;
      count_q    <= count_d;
    end
  end

  // Result buffer occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else if (in_xfer) begin
      a_valid_q <= (res_n != 2'd0);
      b_valid_q <= (res_n == 2'd2);
    end else if (out_xfer) begin
      a_valid_q <= b_valid_q;
      b_valid_q <= 1'b0;
    end
  end

  // Result buffer payload.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_q <= res[0];
      b_q <= res[1];
    end else if (out_xfer) begin
      a_q <= b_q;
    end
  end

  assign out_valid_o   = a_valid_q;
  assign out_byte_o    = a_q.out_byte;
  assign event_res_o   = a_q.ev;
  assign field_index_o = a_q.field_index;
  assign last_o        = a_q.last;

  // The second slot is only ever filled behind a full first slot.
  assert property (@(posedge clk_i) disable iff (!rst_ni) b_valid_q |-> a_valid_q)
    else $error("second result slot valid while first slot empty");

  // A pair of results is never marked last on its first entry.
  assert property (@(posedge clk_i) disable iff (!rst_ni) b_valid_q |-> !a_q.last)
    else $error("first of two results marked last");

  // A held line end only exists in the value phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni) eol_q |-> phase_q == PH_VALUE)
    else $error("line end pending outside value phase");

  // A stopped parser gives no result until the next first byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_xfer && !first_i && phase_q == PH_STOP |=> !a_valid_q)
    else $error("result produced while stopped");

  // The field count only steps by one unless the parser restarts.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_xfer && !first_i |=>
                   count_q == $past(count_q) || count_q == $past(count_q) + 16'd1)
    else $error("field count jumped");

endmodule

`default_nettype wire
